FILE: rtl/core/spvp_pkg.sv
// Shared types and constants of the polyphonic sample voice player.
`timescale 1ns / 1ps

package spvp_pkg;

  // Item opcodes
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_TRIGGER = 2'd1,
    OP_WRITE   = 2'd2,
    OP_SILENCE = 2'd3
  } op_t;

  // Control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_DRAIN,
    ST_OUT,
    ST_SCAN,
    ST_CLAIM
  } state_t;

  // Configuration port
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_LENGTH = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_VOLUME = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_STEREO = 2'd2;

  // Field and register widths
  localparam int LEN_CFG_W = 17;
  localparam int VOL_W     = 16;
  localparam int VEL_W     = 7;
  localparam int ADDR_IN_W = 16;
  localparam int SAMPLE_W  = 16;
  localparam int ENTRY_W   = 32;
  localparam int GAIN_W    = 16;
  localparam int MASK_W    = 8;

  localparam logic [VOL_W-1:0] VOL_RESET = 16'd52429;
  // Volume at or below this (about 0.001 of full scale) gates triggers off
  localparam logic [VOL_W-1:0] VOL_GATE  = 16'd65;

  // Gain = floor(velocity * volume / 127) by reciprocal multiply and one correction
  localparam int PROD_W      = VEL_W + VOL_W;
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W     = 24;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd127);
  localparam logic [PROD_W:0]    GAIN_DIV = (PROD_W + 1)'(127);

  // Mix arithmetic
  localparam int TERM_W    = 34;
  localparam int MIX_SHIFT = 17;
  localparam logic [SAMPLE_W-1:0] SAT_POS = 16'h7fff;
  localparam logic [SAMPLE_W-1:0] SAT_NEG = 16'h8000;

endpackage

FILE: rtl/core/spvp_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module spvp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/spvp_gain.sv
// Trigger gain unit: floor(clamped velocity * volume / 127) over three stages.
`timescale 1ns / 1ps

module spvp_gain (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [spvp_pkg::VEL_W-1:0]    velocity,
  input  logic [spvp_pkg::VOL_W-1:0]    volume,
  output logic [spvp_pkg::GAIN_W-1:0]   gain,
  output logic                          done
);

  localparam int PW = spvp_pkg::PROD_W;
  localparam int QW = PW + spvp_pkg::RECIP_W;

  logic [spvp_pkg::VEL_W-1:0]  vel_c;
  logic                        s1_valid;
  logic [PW-1:0]               s1_prod;
  logic                        s2_valid;
  logic [PW-1:0]               s2_prod;
  logic [spvp_pkg::GAIN_W-1:0] s2_quot;
  logic [QW-1:0]               recip_prod;
  logic [PW:0]                 rem;

  // Clamp velocity to at least one
  assign vel_c = (velocity == '0) ? spvp_pkg::VEL_W'(1) : velocity;

  assign recip_prod = QW'(s1_prod) * QW'(spvp_pkg::RECIP);
  // Estimate is the quotient or one short of it
  assign rem = (PW + 1)'(s2_prod) - (PW + 1)'(s2_quot) * spvp_pkg::GAIN_DIV;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= start;
      s2_valid <= s1_valid;
      if (start) begin
        done <= 1'b0;
      end else if (s2_valid) begin
        done <= 1'b1;
      end
    end
    s1_prod <= PW'(vel_c) * PW'(volume);
    s2_prod <= s1_prod;
    s2_quot <= recip_prod[spvp_pkg::RECIP_SHIFT +: spvp_pkg::GAIN_W];
    if (s2_valid) begin
      gain <= (rem >= spvp_pkg::GAIN_DIV) ? s2_quot + spvp_pkg::GAIN_W'(1) : s2_quot;
    end
  end

endmodule

FILE: rtl/core/polyphonic_sample_voice_player.sv
// Polyphonic sample voice player: top level with sequencer, mix datapath and APB registers.
`timescale 1ns / 1ps

// The block plays one sample held in its sample store on up to VOICES voices at
// once. Load the store with write items, set the length, volume and stereo mode
// through the APB registers, then send trigger items to start voices and one tick
// item per audio sample; each tick returns one item with the saturated mix, a clip
// flag and the active mask of voices 0 to 7. A trigger takes the first idle voice
// or, with all voices busy, the one that has played furthest. Voice position and
// gain sit in a small voice memory and the sample entries in the sample store,
// both read in the cycle after the address. A tick sweeps the voice memory one voice
// per cycle, drains the pipeline and then, if the previous result has not been
// taken, waits for it before it returns to ready; a trigger goes straight to the
// claim when a voice is idle and otherwise first searches for the voice to steal,
// the search being one voice memory read per cycle; a gated-off trigger, write
// and silence items are taken without leaving the idle state. Entries of the store
// that were never written read back as whatever the memory holds.
module polyphonic_sample_voice_player #(
  parameter int VOICES       = 8,
  parameter int SAMPLE_DEPTH = 65536
) (
  input  logic                              clk,
  input  logic                              rst,
  // APB configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [spvp_pkg::PADDR_W-1:0]      paddr,
  input  logic [spvp_pkg::PDATA_W-1:0]      pwdata,
  output logic [spvp_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready,
  // Command items
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  logic [1:0]                        op,
  input  logic [spvp_pkg::VEL_W-1:0]        velocity,
  input  logic [spvp_pkg::ADDR_IN_W-1:0]    store_address,
  input  logic signed [spvp_pkg::SAMPLE_W-1:0] left_sample,
  input  logic signed [spvp_pkg::SAMPLE_W-1:0] right_sample,
  // Mix result items
  output logic                              mix_valid,
  input  logic                              mix_ready,
  output logic signed [spvp_pkg::SAMPLE_W-1:0] mix_sample,
  output logic                              clipped,
  output logic [spvp_pkg::MASK_W-1:0]       active_mask
);

  localparam int ADDR_W  = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int POS_W   = $clog2(SAMPLE_DEPTH + 1);
  localparam int LEN_W   = (POS_W > spvp_pkg::LEN_CFG_W) ? POS_W : spvp_pkg::LEN_CFG_W;
  localparam int WA_W    = (POS_W > spvp_pkg::ADDR_IN_W) ? POS_W : spvp_pkg::ADDR_IN_W;
  localparam int VIDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CNT_W   = $clog2(VOICES + 1);
  localparam int GAIN_W  = spvp_pkg::GAIN_W;
  localparam int VRAM_W  = POS_W + GAIN_W;
  localparam int TERM_W  = spvp_pkg::TERM_W;
  localparam int ACC_W   = TERM_W + CNT_W;
  localparam int MIX_W   = ACC_W - spvp_pkg::MIX_SHIFT;
  localparam int PAD_W   = (VOICES > spvp_pkg::MASK_W) ? VOICES : spvp_pkg::MASK_W;
  localparam int SW      = spvp_pkg::SAMPLE_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [spvp_pkg::LEN_CFG_W-1:0] sample_length;
  logic [spvp_pkg::VOL_W-1:0]     sample_volume;
  logic                           stereo_mode;
  logic                           cfg_we;
  logic [spvp_pkg::REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[spvp_pkg::PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_length <= '0;
      sample_volume <= spvp_pkg::VOL_RESET;
      stereo_mode   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        spvp_pkg::REG_LENGTH: sample_length <= pwdata[spvp_pkg::LEN_CFG_W-1:0];
        spvp_pkg::REG_VOLUME: sample_volume <= pwdata[spvp_pkg::VOL_W-1:0];
        spvp_pkg::REG_STEREO: stereo_mode   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      spvp_pkg::REG_LENGTH: prdata = spvp_pkg::PDATA_W'(sample_length);
      spvp_pkg::REG_VOLUME: prdata = spvp_pkg::PDATA_W'(sample_volume);
      spvp_pkg::REG_STEREO: prdata = spvp_pkg::PDATA_W'(stereo_mode);
      default:              prdata = '0;
    endcase
  end

  // Length beyond the store acts as the whole store
  logic [POS_W-1:0] len_eff;
  logic             len_zero;
  logic             gate_ok;

  assign len_eff  = (LEN_W'(sample_length) > LEN_W'(SAMPLE_DEPTH)) ?
                    POS_W'(SAMPLE_DEPTH) : POS_W'(sample_length);
  assign len_zero = (sample_length == '0);
  assign gate_ok  = !len_zero && (sample_volume > spvp_pkg::VOL_GATE);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  spvp_pkg::state_t state, state_next;
  spvp_pkg::op_t    cmd_op;

  logic              cmd_fire;
  logic              tick_start;
  logic              trig_start;
  logic              write_fire;
  logic              silence_fire;
  logic              issue;
  logic              claim_we;
  logic              out_load;
  logic [CNT_W-1:0]  iss;
  logic [VIDX_W-1:0] iss_idx;
  logic              last_issue;

  // Voice pipeline: a = voice memory data, b = store data, c = gain-scaled term
  logic              a_valid;
  logic              sc_valid;
  logic              b_valid;
  logic              c_valid;
  logic              gain_done;

  assign cmd_op     = spvp_pkg::op_t'(op);
  assign cmd_ready  = (state == spvp_pkg::ST_IDLE);
  assign cmd_fire   = cmd_valid && cmd_ready;
  assign iss_idx    = iss[VIDX_W-1:0];
  assign last_issue = (iss == CNT_W'(VOICES - 1));

  logic any_free;
  logic [VIDX_W-1:0] free_idx;
  logic [VOICES-1:0] voice_active;

  // First idle voice, lowest index wins
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!voice_active[i]) begin
        any_free = 1'b1;
        free_idx = VIDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spvp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    tick_start   = 1'b0;
    trig_start   = 1'b0;
    write_fire   = 1'b0;
    silence_fire = 1'b0;
    issue        = 1'b0;
    claim_we     = 1'b0;
    out_load     = 1'b0;
    case (state)
      spvp_pkg::ST_IDLE: begin
        if (cmd_fire) begin
          case (cmd_op)
            spvp_pkg::OP_TICK: begin
              tick_start = 1'b1;
              state_next = spvp_pkg::ST_TICK;
            end
            spvp_pkg::OP_TRIGGER: begin
              if (gate_ok) begin
                trig_start = 1'b1;
                state_next = any_free ? spvp_pkg::ST_CLAIM : spvp_pkg::ST_SCAN;
              end
            end
            spvp_pkg::OP_WRITE:   write_fire   = 1'b1;
            spvp_pkg::OP_SILENCE: silence_fire = 1'b1;
            default: ;
          endcase
        end
      end
      spvp_pkg::ST_TICK: begin
        issue = 1'b1;
        if (last_issue) begin
          state_next = spvp_pkg::ST_DRAIN;
        end
      end
      spvp_pkg::ST_DRAIN: begin
        if (!(a_valid || b_valid || c_valid)) begin
          state_next = spvp_pkg::ST_OUT;
        end
      end
      spvp_pkg::ST_OUT: begin
        // Hold the finished mix until the previous result has gone
        if (!mix_valid || mix_ready) begin
          out_load   = 1'b1;
          state_next = spvp_pkg::ST_IDLE;
        end
      end
      spvp_pkg::ST_SCAN: begin
        issue = 1'b1;
        if (last_issue) begin
          state_next = spvp_pkg::ST_CLAIM;
        end
      end
      spvp_pkg::ST_CLAIM: begin
        if (gain_done && !sc_valid) begin
          claim_we   = 1'b1;
          state_next = spvp_pkg::ST_IDLE;
        end
      end
      default: state_next = spvp_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  logic [VRAM_W-1:0] vram_rdata;
  logic [VRAM_W-1:0] vram_wdata;
  logic [VIDX_W-1:0] vram_waddr;
  logic              vram_we;
  logic [POS_W-1:0]  vpos;
  logic [GAIN_W-1:0] vgain;
  logic [VIDX_W-1:0] rd_voice;
  logic              retire;
  logic              advance;
  logic [VIDX_W-1:0] pick;
  logic [GAIN_W-1:0] new_gain;
  logic [spvp_pkg::ENTRY_W-1:0] st_rdata;
  logic              st_we;

  assign vpos    = vram_rdata[VRAM_W-1:GAIN_W];
  assign vgain   = vram_rdata[GAIN_W-1:0];
  assign retire  = a_valid && (vpos >= len_eff);
  assign advance = a_valid && !retire;

  // Write back the advanced position; a claim restarts the picked voice
  assign vram_we    = advance || claim_we;
  assign vram_waddr = claim_we ? pick : rd_voice;
  assign vram_wdata = claim_we ? {POS_W'(0), new_gain} : {vpos + POS_W'(1), vgain};

  // Drop writes beyond the store
  assign st_we = write_fire && (WA_W'(store_address) < WA_W'(SAMPLE_DEPTH));

  spvp_ram #(
    .WIDTH (VRAM_W),
    .DEPTH (VOICES)
  ) u_voice_ram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vram_wdata),
    .raddr (iss_idx),
    .rdata (vram_rdata)
  );

  spvp_ram #(
    .WIDTH (spvp_pkg::ENTRY_W),
    .DEPTH (SAMPLE_DEPTH)
  ) u_sample_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (ADDR_W'(store_address)),
    .wdata ({right_sample, left_sample}),
    .raddr (vpos[ADDR_W-1:0]),
    .rdata (st_rdata)
  );

  spvp_gain u_gain (
    .clk      (clk),
    .rst      (rst),
    .start    (trig_start),
    .velocity (velocity),
    .volume   (sample_volume),
    .gain     (new_gain),
    .done     (gain_done)
  );

  // ---------------------------------------------------------------------------
  // Voice sweep and mix datapath
  // ---------------------------------------------------------------------------
  logic [GAIN_W-1:0]        b_gain;
  logic signed [SW:0]       s_val;
  logic signed [SW:0]       g_val;
  logic signed [TERM_W-1:0] term;
  logic signed [TERM_W-1:0] c_term;
  logic signed [ACC_W-1:0]  acc;
  logic [POS_W-1:0]         max_pos;

  // Stereo sums both halves, mono doubles left, so both share one scale
  always_comb begin
    if (stereo_mode) begin
      s_val = $signed({st_rdata[SW-1], st_rdata[SW-1:0]}) +
              $signed({st_rdata[2*SW-1], st_rdata[2*SW-1:SW]});
    end else begin
      s_val = $signed({st_rdata[SW-1:0], 1'b0});
    end
  end

  assign g_val = $signed({1'b0, b_gain});
  assign term  = s_val * g_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      iss          <= '0;
      a_valid      <= 1'b0;
      sc_valid     <= 1'b0;
      b_valid      <= 1'b0;
      c_valid      <= 1'b0;
      voice_active <= '0;
    end else begin
      if (issue) begin
        iss <= iss + CNT_W'(1);
      end else if (state == spvp_pkg::ST_IDLE) begin
        iss <= '0;
      end
      a_valid  <= (state == spvp_pkg::ST_TICK) && voice_active[iss_idx] && !len_zero;
      sc_valid <= (state == spvp_pkg::ST_SCAN);
      b_valid  <= advance;
      c_valid  <= b_valid;
      if (silence_fire) begin
        voice_active <= '0;
      end else if (retire) begin
        voice_active[rd_voice] <= 1'b0;
      end else if (claim_we) begin
        voice_active[pick] <= 1'b1;
      end
    end
    rd_voice <= iss_idx;
    b_gain   <= vgain;
    c_term   <= term;
    if (tick_start) begin
      acc <= '0;
    end else if (c_valid) begin
      acc <= acc + ACC_W'(c_term);
    end
    // Picked voice: first idle one, else steal search by furthest position, first on a tie
    if (trig_start && any_free) begin
      pick <= free_idx;
    end else if (sc_valid && ((rd_voice == '0) || (vpos > max_pos))) begin
      pick    <= rd_voice;
      max_pos <= vpos;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [MIX_W-1:0]  mix_hi;
  logic              mix_fits;
  logic [PAD_W-1:0]  active_pad;

  // Arithmetic shift rounds toward minus infinity
  assign mix_hi     = acc[ACC_W-1:spvp_pkg::MIX_SHIFT];
  assign mix_fits   = (&mix_hi[MIX_W-1:SW-1]) || !(|mix_hi[MIX_W-1:SW-1]);
  assign active_pad = PAD_W'(voice_active);

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_valid <= 1'b0;
    end else if (out_load) begin
      mix_valid <= 1'b1;
    end else if (mix_ready) begin
      mix_valid <= 1'b0;
    end
    if (out_load) begin
      mix_sample  <= mix_fits ? mix_hi[SW-1:0] :
                     (mix_hi[MIX_W-1] ? spvp_pkg::SAT_NEG : spvp_pkg::SAT_POS);
      clipped     <= !mix_fits;
      active_mask <= active_pad[spvp_pkg::MASK_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == spvp_pkg::ST_IDLE) |-> !(a_valid || b_valid || c_valid || sc_valid))
    else $error("voice pipeline busy while idle");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(mix_valid) |-> $past(state == spvp_pkg::ST_OUT))
    else $error("result raised outside the output state");

  a_claim_sets_voice: assert property (@(posedge clk) disable iff (rst)
    claim_we |=> voice_active[pick])
    else $error("claimed voice not active");

  a_claim_gated: assert property (@(posedge clk) disable iff (rst)
    (state == spvp_pkg::ST_CLAIM) |-> (sample_length != '0))
    else $error("claim without a loaded sample");

endmodule
